// File: hw/rtl/prcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcc_pkg
// Shared types and constants of the packet reorder and concealment control.
// ----------------------------------------------------------------------------
package prcc_pkg;

    localparam int HoldSlots    = 3;
    localparam int ConcealSteps = 4;
    localparam int SlotW        = 3;
    localparam int SlotIdxW     = (HoldSlots > 1) ? $clog2(HoldSlots) : 1;

    localparam logic [30:0] RestartGapRst  = 31'd3000;
    localparam logic [9:0]  MaxLenRst      = 10'd800;
    localparam logic [9:0]  ConcealLenRst  = 10'd480;

    localparam logic [1:0] RegRestartGap = 2'd0;
    localparam logic [1:0] RegMaxLen     = 2'd1;
    localparam logic [1:0] RegConcealLen = 2'd2;

    typedef enum logic [2:0] {
        ACT_PLAY    = 3'd0,
        ACT_HELD    = 3'd1,
        ACT_CONCEAL = 3'd2,
        ACT_PARK    = 3'd3,
        ACT_DROP    = 3'd4,
        ACT_REJECT  = 3'd5,
        ACT_CLEAR   = 3'd6
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FLUSH,
        ST_RESUME,
        ST_CONCEAL,
        ST_GIVEUP,
        ST_AFTER
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;
        logic       clear;
        logic       reject;
        logic       first;
        logic       restart;
        logic       late_drop;
        logic       play;
        logic       park;
        logic       park_low;
        logic       flush_step;
        logic       resume_step;
        logic       conceal;
        logic       giveup;
        logic       final_drop;
        logic       last;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad_len;
        logic seq_valid;
        logic behind;
        logic far_behind;
        logic equal;
        logic near;
        logic free_any;
        logic flush_hit;
        logic chain_more;
        logic resume_done;
        logic conceal_more;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/packet_reorder_conceal_control_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_reorder_conceal_control_core
// Jitter buffer reorder and loss concealment controller.
// ----------------------------------------------------------------------------
// One transaction is taken when start is high and busy is low. Results
// appear on o_strobe, at most one per cycle, and cannot be held off. A clear
// leaves busy low and gives its result in the next cycle; a rejected, late or
// parked packet gives a single result; an in-order packet gives its own result
// and one more for each parked packet it releases; a gap runs the three-slot
// scan, up to four concealment steps, the give-up step, the flush of the hold
// and the final decision of the controller.
module packet_reorder_conceal_control_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_seq,
    input  wire logic [10:0] i_length,
    output logic             o_strobe,
    output logic [2:0]       o_action,
    output logic [2:0]       o_slot,
    output logic [1:0]       o_fade_step,
    output logic [9:0]       o_play_len,
    output logic [31:0]      o_seq_out,
    output logic             o_last,
    output logic [31:0]      o_delivered_count,
    output logic [31:0]      o_concealed_count,
    output logic [31:0]      o_reordered_count,
    output logic [31:0]      o_dropped_count,
    output logic [31:0]      o_restart_count
);

    prcc_pkg::t_cmd    w_cmd;
    prcc_pkg::t_status w_st;

    prcc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_go(start),
        .i_command,
        .i_st(w_st),
        .o_busy(busy),
        .o_cmd(w_cmd)
    );

    prcc_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_seq, .i_length,
        .i_cmd(w_cmd),
        .o_st(w_st),
        .o_strobe, .o_action, .o_slot, .o_fade_step, .o_play_len, .o_seq_out,
        .o_last, .o_delivered_count, .o_concealed_count, .o_reordered_count,
        .o_dropped_count, .o_restart_count
    );

endmodule
`default_nettype wire

// File: hw/rtl/prcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcc_ctrl
// Controller that sequences the decision and emits datapath commands.
// ----------------------------------------------------------------------------
module prcc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic               i_command,
    input  prcc_pkg::t_status       i_st,
    output logic                    o_busy,
    output prcc_pkg::t_cmd          o_cmd
);

    prcc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != prcc_pkg::ST_IDLE);
        case (r_state)
            prcc_pkg::ST_IDLE: begin
                if (i_go) begin
                    o_cmd.load = 1'b1;
                    if (i_command) begin
                        o_cmd.clear = 1'b1;
                        o_cmd.last  = 1'b1;
                    end else begin
                        n_state = prcc_pkg::ST_DECIDE;
                    end
                end
            end
            prcc_pkg::ST_DECIDE: begin
                n_state = prcc_pkg::ST_IDLE;
                if (i_st.bad_len) begin
                    o_cmd.reject = 1'b1;
                    o_cmd.last = 1'b1;
                end else if (!i_st.seq_valid) begin
                    o_cmd.first = 1'b1;
                    o_cmd.last = 1'b1;
                end else if (i_st.behind) begin
                    o_cmd.last = 1'b1;
                    if (i_st.far_behind) o_cmd.restart = 1'b1;
                    else o_cmd.late_drop = 1'b1;
                end else if (i_st.equal) begin
                    o_cmd.play = 1'b1;
                    o_cmd.last = !i_st.chain_more;
                    if (i_st.chain_more) n_state = prcc_pkg::ST_FLUSH;
                end else if (i_st.near && i_st.free_any) begin
                    o_cmd.park = 1'b1;
                    o_cmd.last = 1'b1;
                end else begin
                    n_state = prcc_pkg::ST_RESUME;
                end
            end
            prcc_pkg::ST_RESUME: begin
                o_cmd.resume_step = 1'b1;
                if (i_st.resume_done) n_state = prcc_pkg::ST_CONCEAL;
            end
            prcc_pkg::ST_CONCEAL: begin
                if (i_st.conceal_more) begin
                    o_cmd.conceal = 1'b1;
                end else begin
                    o_cmd.giveup = 1'b1;
                    n_state = prcc_pkg::ST_GIVEUP;
                end
            end
            prcc_pkg::ST_GIVEUP: begin
                // Flush parked packets that resume the stream.
                if (i_st.flush_hit) begin
                    o_cmd.flush_step = 1'b1;
                end else begin
                    n_state = prcc_pkg::ST_AFTER;
                end
            end
            prcc_pkg::ST_AFTER: begin
                n_state = prcc_pkg::ST_IDLE;
                if (i_st.equal) begin
                    o_cmd.play = 1'b1;
                    o_cmd.last = !i_st.chain_more;
                    if (i_st.chain_more) n_state = prcc_pkg::ST_FLUSH;
                end else if (!i_st.behind && i_st.free_any) begin
                    o_cmd.park = 1'b1;
                    o_cmd.park_low = 1'b1;
                    o_cmd.last = 1'b1;
                end else begin
                    o_cmd.final_drop = 1'b1;
                    o_cmd.last = 1'b1;
                end
            end
            prcc_pkg::ST_FLUSH: begin
                o_cmd.flush_step = 1'b1;
                o_cmd.last = !i_st.chain_more;
                if (!i_st.chain_more) n_state = prcc_pkg::ST_IDLE;
            end
            default: n_state = prcc_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/prcc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcc_dp
// Datapath: sequence state, hold slots, counters and the result register.
// ----------------------------------------------------------------------------
module prcc_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [30:0]    i_cfg_data,
    input  wire logic [31:0]    i_seq,
    input  wire logic [10:0]    i_length,
    input  prcc_pkg::t_cmd      i_cmd,
    output prcc_pkg::t_status   o_st,
    output logic                o_strobe,
    output logic [2:0]          o_action,
    output logic [2:0]          o_slot,
    output logic [1:0]          o_fade_step,
    output logic [9:0]          o_play_len,
    output logic [31:0]         o_seq_out,
    output logic                o_last,
    output logic [31:0]         o_delivered_count,
    output logic [31:0]         o_concealed_count,
    output logic [31:0]         o_reordered_count,
    output logic [31:0]         o_dropped_count,
    output logic [31:0]         o_restart_count
);

    localparam int H = prcc_pkg::HoldSlots;

    logic [30:0] r_gap;
    logic [9:0]  r_max_len, r_def_len;
    logic [31:0] r_seq;
    logic [10:0] r_len;
    logic        r_have;
    logic [31:0] r_exp;
    logic [H-1:0] r_used;
    logic [31:0] r_sseq [H];
    logic [9:0]  r_slen [H];
    logic [9:0]  r_last_len;
    logic [31:0] r_dlv, r_cnc, r_reo, r_drp, r_rst;
    logic [31:0] r_resume;
    logic [prcc_pkg::SlotIdxW-1:0] r_ridx;
    logic [prcc_pkg::SlotIdxW-1:0] r_prev;
    logic        r_chain;
    logic [31:0] r_miss;
    logic [2:0]  r_k;

    logic        r_strobe, r_last;
    logic [2:0]  r_action, r_slot;
    logic [1:0]  r_fade;
    logic [9:0]  r_plen;
    logic [31:0] r_sout;

    logic [31:0] w_delta;
    logic        w_hit, w_hit_up;
    logic [prcc_pkg::SlotIdxW-1:0] w_hit_idx, w_hit_lo_idx, w_hit_up_idx;
    logic [prcc_pkg::SlotIdxW-1:0] w_free_idx, w_free_lo_idx, w_park_idx;
    logic        w_free;
    logic [31:0] w_rd;
    logic [31:0] w_exp_emit;
    logic [9:0]  w_clen;

    assign w_delta = r_seq - r_exp;
    assign w_rd    = r_sseq[r_ridx] - r_resume;

    // Within one flush pass the next match is searched above the slot just
    // played; when none is left there, a new pass starts from the lowest slot.
    always_comb begin
        w_hit = 1'b0;
        w_hit_lo_idx = '0;
        w_hit_up = 1'b0;
        w_hit_up_idx = '0;
        w_free = 1'b0;
        w_free_idx = '0;
        w_free_lo_idx = '0;
        for (int i = H - 1; i >= 0; i--) begin
            if (r_used[i] && r_sseq[i] == r_exp) begin
                w_hit = 1'b1;
                w_hit_lo_idx = prcc_pkg::SlotIdxW'(i);
                if (r_chain && prcc_pkg::SlotIdxW'(i) > r_prev) begin
                    w_hit_up = 1'b1;
                    w_hit_up_idx = prcc_pkg::SlotIdxW'(i);
                end
            end
            if (!r_used[i]) begin
                w_free_lo_idx = prcc_pkg::SlotIdxW'(i);
            end
        end
        for (int i = 0; i < H; i++) begin
            if (!r_used[i]) begin
                w_free = 1'b1;
                w_free_idx = prcc_pkg::SlotIdxW'(i);
            end
        end
    end

    assign w_hit_idx  = w_hit_up ? w_hit_up_idx : w_hit_lo_idx;
    assign w_park_idx = i_cmd.park_low ? w_free_lo_idx : w_free_idx;

    assign w_clen = (r_last_len != '0) ? r_last_len : r_def_len;
    assign w_exp_emit = r_exp + 32'(r_k);

    logic w_more_flush;
    always_comb begin
        w_more_flush = 1'b0;
        for (int i = 0; i < H; i++) begin
            if (r_used[i] && !(w_hit && prcc_pkg::SlotIdxW'(i) == w_hit_idx) &&
                r_sseq[i] == r_exp + 32'd1)
                w_more_flush = 1'b1;
        end
    end

    always_comb begin
        o_st.bad_len = (r_len == '0) || (r_len > {1'b0, r_max_len});
        o_st.seq_valid = r_have;
        o_st.behind = w_delta[31];
        o_st.far_behind = ({1'b0, (~w_delta)} + 33'd1) > {2'b00, r_gap};
        o_st.equal = (w_delta == '0);
        o_st.near = (w_delta <= 32'(H));
        o_st.free_any = w_free;
        o_st.flush_hit = w_hit;
        o_st.chain_more = w_more_flush;
        o_st.resume_done = (32'(r_ridx) >= 32'(H - 1));
        o_st.conceal_more = (r_k < 3'(prcc_pkg::ConcealSteps)) &&
                            !r_miss[31] && (32'(r_k) < r_miss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= prcc_pkg::RestartGapRst;
            r_max_len <= prcc_pkg::MaxLenRst;
            r_def_len <= prcc_pkg::ConcealLenRst;
            r_have <= 1'b0;
            r_exp <= '0;
            r_used <= '0;
            r_last_len <= '0;
            r_dlv <= '0; r_cnc <= '0; r_reo <= '0; r_drp <= '0; r_rst <= '0;
            r_strobe <= 1'b0;
            r_last <= 1'b0;
            r_action <= prcc_pkg::ACT_PLAY;
            r_chain <= 1'b0;
            r_prev <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prcc_pkg::RegRestartGap: r_gap <= i_cfg_data;
                    prcc_pkg::RegMaxLen:     r_max_len <= i_cfg_data[9:0];
                    prcc_pkg::RegConcealLen: r_def_len <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_seq <= i_seq;
                r_len <= i_length;
                r_ridx <= '0;
                r_k <= '0;
            end
            if (i_cmd.load || i_cmd.play || i_cmd.giveup) r_chain <= 1'b0;
            if (i_cmd.clear) begin
                r_used <= '0;
                r_have <= 1'b0;
                r_last_len <= '0;
                r_dlv <= '0; r_cnc <= '0; r_reo <= '0; r_drp <= '0; r_rst <= '0;
            end
            r_slot <= '0;
            r_fade <= '0;
            r_plen <= '0;
            r_sout <= r_seq;
            r_last <= i_cmd.last;
            if (i_cmd.clear) begin
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_CLEAR; r_sout <= '0;
            end
            if (i_cmd.reject) begin
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_REJECT;
            end
            if (i_cmd.first || i_cmd.restart || i_cmd.play) begin
                r_have <= 1'b1;
                r_exp <= r_seq + 32'd1;
                r_dlv <= r_dlv + 32'd1;
                r_last_len <= r_len[9:0];
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_PLAY;
                r_plen <= r_len[9:0];
            end
            if (i_cmd.restart) begin
                r_rst <= r_rst + 32'd1;
                r_used <= '0;
            end
            if (i_cmd.late_drop || i_cmd.final_drop) begin
                r_drp <= r_drp + 32'd1;
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_DROP;
            end
            if (i_cmd.park) begin
                r_used[w_park_idx] <= 1'b1;
                r_sseq[w_park_idx] <= r_seq;
                r_slen[w_park_idx] <= r_len[9:0];
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_PARK;
                r_slot <= prcc_pkg::SlotW'(w_park_idx); r_plen <= r_len[9:0];
            end
            if (i_cmd.flush_step) begin
                r_used[w_hit_idx] <= 1'b0;
                r_exp <= r_exp + 32'd1;
                r_dlv <= r_dlv + 32'd1;
                r_reo <= r_reo + 32'd1;
                r_last_len <= r_slen[w_hit_idx];
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_HELD;
                r_slot <= prcc_pkg::SlotW'(w_hit_idx); r_plen <= r_slen[w_hit_idx];
                r_sout <= r_sseq[w_hit_idx];
                r_chain <= 1'b1;
                r_prev <= w_hit_idx;
            end
            if (i_cmd.load && !i_cmd.clear) r_resume <= i_seq;
            if (i_cmd.resume_step) begin
                if (r_used[r_ridx] && w_rd[31]) r_resume <= r_sseq[r_ridx];
                r_ridx <= r_ridx + 1'b1;
                r_miss <= r_resume - r_exp;
                if (32'(r_ridx) >= 32'(H - 1)) begin
                    if (r_used[r_ridx] && w_rd[31]) r_miss <= r_sseq[r_ridx] - r_exp;
                end
            end
            if (i_cmd.conceal) begin
                r_cnc <= r_cnc + 32'd1;
                r_k <= r_k + 3'd1;
                r_strobe <= 1'b1; r_action <= prcc_pkg::ACT_CONCEAL;
                r_fade <= r_k[1:0]; r_plen <= w_clen; r_sout <= w_exp_emit;
            end
            if (i_cmd.giveup) begin
                if (!r_miss[31] && r_miss > 32'(prcc_pkg::ConcealSteps))
                    r_drp <= r_drp + r_miss - 32'(prcc_pkg::ConcealSteps);
                r_exp <= r_resume;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_action = r_action;
    assign o_slot = r_slot;
    assign o_fade_step = r_fade;
    assign o_play_len = r_plen;
    assign o_seq_out = r_sout;
    assign o_last = r_last;
    assign o_delivered_count = r_dlv;
    assign o_concealed_count = r_cnc;
    assign o_reordered_count = r_reo;
    assign o_dropped_count = r_drp;
    assign o_restart_count = r_rst;

endmodule
`default_nettype wire

// File: hw/rtl/prcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcc_checker
// Port-level checks of the reorder and concealment controller.
// ----------------------------------------------------------------------------
module prcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic        o_last,
    input wire logic [2:0]  o_action,
    input wire logic [31:0] o_delivered_count
);

    ap_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe) else $error("last without strobe");

    ap_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_action == prcc_pkg::ACT_CLEAR) |-> o_delivered_count == '0)
        else $error("clear left counters");

    ap_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_action == prcc_pkg::ACT_CLEAR) |-> o_last)
        else $error("clear not final");

    ap_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy during final result");

endmodule

bind packet_reorder_conceal_control_core prcc_checker u_prcc_checker (
    .i_clk, .i_rst_n, .busy, .o_strobe, .o_last, .o_action, .o_delivered_count
);
`default_nettype wire
